// ----- hw/rtl/qdel_pkg.sv -----
// qdel_pkg: shared types, constants and the transition table
// for the quadrature decoder with event log; no dependencies
package qdel_pkg;

    localparam int EVENT_SLOTS = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_IDX_W  = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int FILL_W      = $clog2(EVENT_SLOTS + 1);

    // register indexes on the apb port
    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_CMIN = 2'd1;
    localparam logic [1:0] REG_CMAX = 2'd2;

    // input commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    // resolution selector codes
    localparam logic [1:0] RES_X1 = 2'd0;
    localparam logic [1:0] RES_X2 = 2'd1;
    localparam logic [1:0] RES_X4 = 2'd2;

    // table entry fields
    localparam logic [15:0] PHASE_MASK = 16'h001C;
    localparam logic [15:0] INC_BITS   = 16'h0700;
    localparam logic [15:0] DEC_BITS   = 16'h7000;
    localparam logic [15:0] INC1       = 16'h0100;
    localparam logic [15:0] INC2       = 16'h0300;
    localparam logic [15:0] INC4       = 16'h0700;
    localparam logic [15:0] DEC1       = 16'h1000;
    localparam logic [15:0] DEC2       = 16'h3000;
    localparam logic [15:0] DEC4       = 16'h7000;
    localparam logic [15:0] CW         = 16'h0010;
    localparam logic [15:0] S1         = 16'h0004;
    localparam logic [15:0] S2         = 16'h0008;
    localparam logic [15:0] S3         = 16'h000C;

    localparam logic [15:0] TRANS_TABLE [32] = '{
        16'h0000,       CW | S1 | INC1, 16'h0000,       S3 | DEC4,
        S1,             S1,             DEC1,           CW | S2 | INC4,
        S1 | DEC2,      S2,             CW | S3 | INC1, S2,
        CW | INC2,      S2 | DEC1,      S3,             S3,
        CW,             CW | S1 | INC1, CW,             S3 | DEC4,
        CW | S1,        CW | S1,        DEC1,           CW | S2 | INC4,
        S1 | DEC2,      CW | S2,        CW | S3 | INC1, CW | S2,
        CW | INC2,      S2 | DEC1,      CW | S3,        CW | S3
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic in_load;
        logic sample_exec;
        logic poll_exec;
        logic load_slot;
        logic drain_next;
        logic drain_done;
    } t_dp_cmd;

    typedef struct packed {
        logic is_poll;
        logic out_last;
    } t_dp_status;

endpackage

// ----- hw/rtl/qdel_ctrl.sv -----
// qdel_ctrl: sequencer for sample, poll and log drain
// depends on qdel_pkg
module qdel_ctrl import qdel_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_poll) begin
                    o_cmd.poll_exec = 1'b1;
                    n_state         = ST_LOAD;
                end else begin
                    o_cmd.sample_exec = 1'b1;
                    n_state           = ST_OUT;
                end
            end
            ST_LOAD: begin
                o_cmd.load_slot = 1'b1;
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (i_status.is_poll && !i_status.out_last) begin
                        o_cmd.drain_next = 1'b1;
                        n_state          = ST_LOAD;
                    end else begin
                        o_cmd.drain_done = i_status.is_poll;
                        n_state          = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/qdel_dp.sv -----
// qdel_dp: phase state, counter, run-length log, config registers, output beat
// depends on qdel_pkg
module qdel_dp import qdel_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    output t_dp_status                    o_status,
    input  logic                          i_cmd_in,
    input  logic                          i_pin_a,
    input  logic                          i_pin_b,
    input  logic                          i_index_pin,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    output logic [31:0]                   o_cfg_rdata,
    output logic signed [COUNT_WIDTH-1:0] o_count_value,
    output logic signed [1:0]             o_step_dir,
    output logic signed [7:0]             o_slot_value,
    output logic                          o_log_overflow,
    output logic                          o_last_of_run
);

    logic [1:0]                    r_mode;
    logic signed [COUNT_WIDTH-1:0] r_cmin;
    logic signed [COUNT_WIDTH-1:0] r_cmax;
    logic [4:0]                    r_phase;
    logic signed [COUNT_WIDTH-1:0] r_count;
    logic signed [7:0]             r_slots [EVENT_SLOTS];
    logic signed [7:0]             r_tail;
    logic [FILL_W-1:0]             r_fill;
    logic                          r_ovf;
    logic                          r_first;
    logic                          r_in_cmd;
    logic                          r_in_a;
    logic                          r_in_b;
    logic                          r_in_index;
    logic [SLOT_IDX_W-1:0]         r_ptr;
    logic                          r_poll_ovf;

    logic [4:0]                    idx;
    logic [15:0]                   entry;
    logic [15:0]                   res_mask;
    logic [15:0]                   sel;
    logic                          inc;
    logic                          dec;
    logic signed [COUNT_WIDTH-1:0] n_count;
    logic signed [1:0]             dir;
    logic signed [7:0]             dir8;
    logic                          open_new;
    logic                          ptr_last;

    // transition lookup and resolution masking
    always_comb begin
        idx   = {r_phase[4:2], r_in_b, r_in_a};
        entry = TRANS_TABLE[idx];
        priority if (r_mode == RES_X1) begin
            res_mask = INC1 | DEC1;
        end else if (r_mode == RES_X2) begin
            res_mask = INC2 | DEC2;
        end else begin
            res_mask = INC4 | DEC4;
        end
        sel = entry & res_mask;
        inc = |(sel & INC_BITS);
        dec = |(sel & DEC_BITS);
    end

    // saturating counter step
    always_comb begin
        n_count = r_count;
        dir     = 2'sd0;
        if (dec) begin
            dir = -2'sd1;
            if (r_count > r_cmin) begin
                n_count = r_count - COUNT_WIDTH'(1);
            end
        end else if (inc) begin
            dir = 2'sd1;
            if (r_count < r_cmax) begin
                n_count = r_count + COUNT_WIDTH'(1);
            end
        end
        dir8     = 8'(dir);
        open_new = (r_fill == '0) || (r_tail[7] != dec)
                   || (r_tail == -8'sd128) || (r_tail == 8'sd127);
    end

    assign ptr_last = (r_fill == '0) || (FILL_W'(r_ptr) == r_fill - FILL_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= RES_X4;
            r_cmin   <= {1'b1, {(COUNT_WIDTH-1){1'b0}}};
            r_cmax   <= {1'b0, {(COUNT_WIDTH-1){1'b1}}};
            r_phase  <= '0;
            r_count  <= '0;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_first  <= 1'b1;
            r_in_cmd <= CMD_SAMPLE;
            r_ptr    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MODE: r_mode <= i_cfg_data[1:0];
                    REG_CMIN: r_cmin <= i_cfg_data;
                    REG_CMAX: r_cmax <= i_cfg_data;
                    default:  ;
                endcase
            end
            if (i_cmd.in_load) begin
                r_in_cmd <= i_cmd_in;
            end
            if (i_cmd.sample_exec) begin
                r_count <= n_count;
                r_phase <= entry[4:0];
                r_first <= 1'b0;
                if ((inc || dec) && !r_first) begin
                    if (open_new) begin
                        if (r_fill < FILL_W'(EVENT_SLOTS)) begin
                            r_slots[r_fill[SLOT_IDX_W-1:0]] <= dir8;
                            r_tail                          <= dir8;
                            r_fill                          <= r_fill + FILL_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end else begin
                        r_slots[r_fill[SLOT_IDX_W-1:0] - SLOT_IDX_W'(1)] <= r_tail + dir8;
                        r_tail <= r_tail + dir8;
                    end
                end
            end
            if (i_cmd.poll_exec) begin
                r_ovf <= 1'b0;
                r_ptr <= '0;
                if (r_in_index) begin
                    r_count <= '0;
                end
            end
            if (i_cmd.drain_next) begin
                r_ptr <= r_ptr + SLOT_IDX_W'(1);
            end
            if (i_cmd.drain_done) begin
                r_fill <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in_a     <= i_pin_a;
            r_in_b     <= i_pin_b;
            r_in_index <= i_index_pin;
        end
        if (i_cmd.poll_exec) begin
            r_poll_ovf <= r_ovf;
        end
        if (i_cmd.sample_exec) begin
            o_count_value  <= n_count;
            o_step_dir     <= dir;
            o_slot_value   <= '0;
            o_log_overflow <= 1'b0;
            o_last_of_run  <= 1'b1;
        end
        if (i_cmd.load_slot) begin
            o_count_value  <= r_count;
            o_step_dir     <= 2'sd0;
            o_slot_value   <= (r_fill == '0) ? 8'sd0 : r_slots[r_ptr];
            o_log_overflow <= r_poll_ovf;
            o_last_of_run  <= ptr_last;
        end
    end

    always_comb begin
        unique case (i_cfg_idx)
            REG_MODE: o_cfg_rdata = {30'd0, r_mode};
            REG_CMIN: o_cfg_rdata = r_cmin;
            REG_CMAX: o_cfg_rdata = r_cmax;
            default:  o_cfg_rdata = '0;
        endcase
    end

    assign o_status.is_poll  = (r_in_cmd == CMD_POLL);
    assign o_status.out_last = o_last_of_run;

endmodule

// ----- hw/rtl/quadrature_decoder_event_log.sv -----
// quadrature_decoder_event_log: x1/x2/x4 quadrature decoder with run-length event log
// depends on qdel_pkg, qdel_ctrl, qdel_dp
//
// usage
//   input channel (i_valid / o_stall): one beat per item; cmd 0 samples pins a and b,
//     cmd 1 polls, applies the index clear and drains the log
//   output channel (o_valid / i_stall): result beats held in an output register;
//     a sample gives one beat, a poll one beat per filled log slot (one zero beat
//     if the log is empty), last_of_run marks the final beat of an item
//   apb port: resolution_mode at 0x0, count_min at 0x4, count_max at 0x8;
//     write only while the block is idle
// timing
//   one item at a time; o_stall is low only while no item is in flight
//   sample: accept, execute, then the result beat
//   poll: accept, execute, then for each result beat a slot read followed by the beat
//   the sequencer in qdel_ctrl sets this step order
// reset
//   synchronous active-low; counter, phase, log and overflow clear, config
//   returns to x4 and full signed range
// stall
//   a stalled result beat holds its payload; no new item is taken until every
//   beat of the current item has gone out
module quadrature_decoder_event_log import qdel_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_cmd,
    input  logic        i_pin_a,
    input  logic        i_pin_b,
    input  logic        i_index_pin,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_count_value,
    output logic [1:0]  o_step_dir,
    output logic [7:0]  o_slot_value,
    output logic        o_log_overflow,
    output logic        o_last_of_run,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_we;

    // zero-wait apb, write completes on the access cycle
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // sequencer: handshakes and step order
    qdel_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    // datapath: decoder state, counter, log and result register
    qdel_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_cmd_in       (i_cmd),
        .i_pin_a        (i_pin_a),
        .i_pin_b        (i_pin_b),
        .i_index_pin    (i_index_pin),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (paddr[3:2]),
        .i_cfg_data     (pwdata),
        .o_cfg_rdata    (prdata),
        .o_count_value  (o_count_value),
        .o_step_dir     (o_step_dir),
        .o_slot_value   (o_slot_value),
        .o_log_overflow (o_log_overflow),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

// ----- test/tb.sv -----
// tb: self-checking bench for quadrature_decoder_event_log, pin samples and log polls
// depends on qdel_pkg for register indexes and command codes, and on the rtl top level
`timescale 1ns / 100ps

module tb;
    import qdel_pkg::*;

    // run limits
    localparam int LIMIT_CYCLES = 600_000;
    localparam int HOLD_AT      = 20;    // result beats seen before the long hold
    localparam int HOLD_CYCLES  = 200;

    // x4 resolution code, and the spare code that also selects x4
    localparam logic [1:0] MODE_X4       = 2'd2;
    localparam logic [1:0] MODE_X4_ALIAS = 2'd3;

    // table entry fields as the decoder sees them
    localparam logic [15:0] STEP_UP   = 16'h0700;
    localparam logic [15:0] STEP_DOWN = 16'h7000;
    localparam logic [15:0] KEEP_X1   = 16'h1100;
    localparam logic [15:0] KEEP_X2   = 16'h3300;
    localparam logic [15:0] KEEP_X4   = 16'h7700;
    localparam logic [4:0]  PHASE_BITS = 5'h1C;

    // next phase and step code, indexed by {phase_state, pin_b, pin_a}
    localparam logic [15:0] STEP_TABLE [32] = '{
        16'h0000, 16'h0114, 16'h0000, 16'h700C,
        16'h0004, 16'h0004, 16'h1000, 16'h0718,
        16'h3004, 16'h0008, 16'h011C, 16'h0008,
        16'h0310, 16'h1008, 16'h000C, 16'h000C,
        16'h0010, 16'h0114, 16'h0010, 16'h700C,
        16'h0014, 16'h0014, 16'h1000, 16'h0718,
        16'h3004, 16'h0018, 16'h011C, 16'h0018,
        16'h0310, 16'h1008, 16'h001C, 16'h001C
    };

    // pin levels {b, a} that move each phase one step forward or back
    localparam logic [1:0] FWD_PINS  [4] = '{2'b01, 2'b11, 2'b10, 2'b00};
    localparam logic [1:0] BACK_PINS [4] = '{2'b11, 2'b10, 2'b00, 2'b01};

    typedef struct packed {
        logic cmd;
        logic pin_a;
        logic pin_b;
        logic index_pin;
    } enc_item_t;

    typedef struct packed {
        logic [31:0] count;
        logic [1:0]  dir;
        logic [7:0]  slot;
        logic        ovf;
        logic        last;
    } enc_report_t;

    // dut ports, inputs all known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_cmd = 1'b0;
    logic        i_pin_a = 1'b0;
    logic        i_pin_b = 1'b0;
    logic        i_index_pin = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_count_value;
    logic [1:0]  o_step_dir;
    logic [7:0]  o_slot_value;
    logic        o_log_overflow;
    logic        o_last_of_run;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    quadrature_decoder_event_log dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // items waiting to be offered, and result beats the decoder owes us
    enc_item_t   encoder_items [$];
    enc_report_t expected_reports [$];
    int          errors = 0;
    int          items_made = 0;

    // ---------------------------------------------------------------
    // decoder prediction: own copy of config and state
    // ---------------------------------------------------------------
    logic [1:0]         res_mode;
    logic signed [31:0] cnt_min;
    logic signed [31:0] cnt_max;
    logic [4:0]         phase_state;
    logic signed [31:0] pos_count;
    int                 log_slots [EVENT_SLOTS];
    logic               lost_steps;
    logic               fresh_start;

    function automatic void reset_decoder();
        res_mode    = MODE_X4;
        cnt_min     = 32'h8000_0000;
        cnt_max     = 32'h7FFF_FFFF;
        phase_state = '0;
        pos_count   = '0;
        foreach (log_slots[k]) log_slots[k] = 0;
        lost_steps  = 1'b0;
        fresh_start = 1'b1;
    endfunction

    // number of leading nonzero slots
    function automatic int used_slots(input int s [EVENT_SLOTS]);
        int n;
        n = 0;
        while (n < EVENT_SLOTS && s[n] != 0) n++;
        return n;
    endfunction

    // same-sign steps merge into the last slot until it reaches +127 or -128
    function automatic void log_run_step(input int dir);
        int n;
        int prev;
        n = used_slots(log_slots);
        prev = (n > 0) ? log_slots[n-1] : 0;
        if (n == 0 || ((prev < 0) != (dir < 0)) || prev == -128 || prev == 127) begin
            if (n < EVENT_SLOTS) log_slots[n] = dir;
            else lost_steps = 1'b1;
        end else begin
            log_slots[n-1] = prev + dir;
        end
    endfunction

    function automatic void decode_item(input enc_item_t it);
        logic [15:0] entry;
        logic [15:0] kept;
        logic [15:0] keep_mask;
        int          dir;
        int          drained [EVENT_SLOTS];
        int          n;
        logic        ovf;
        enc_report_t r;
        if (it.cmd == CMD_SAMPLE) begin
            case (res_mode)
                RES_X1:  keep_mask = KEEP_X1;
                RES_X2:  keep_mask = KEEP_X2;
                default: keep_mask = KEEP_X4;    // x4 and its alias code
            endcase
            entry = STEP_TABLE[(phase_state & PHASE_BITS) | {3'b0, it.pin_b, it.pin_a}];
            kept  = entry & keep_mask;
            dir   = 0;
            // counter saturates at the limits, even when they are inverted
            if ((kept & STEP_UP) != 0) begin
                if (pos_count < cnt_max) pos_count = pos_count + 1;
                dir = 1;
            end
            if ((kept & STEP_DOWN) != 0) begin
                if (pos_count > cnt_min) pos_count = pos_count - 1;
                dir = -1;
            end
            // the very first sample after reset moves the counter but is not logged
            if (dir != 0 && !fresh_start) log_run_step(dir);
            fresh_start = 1'b0;
            phase_state = entry[4:0];
            r = '{count: pos_count, dir: dir[1:0], slot: 8'h00, ovf: 1'b0, last: 1'b1};
            expected_reports.push_back(r);
        end else begin
            // drain first, then the index clear; reported count is after the clear
            drained = log_slots;
            ovf = lost_steps;
            foreach (log_slots[k]) log_slots[k] = 0;
            lost_steps = 1'b0;
            if (it.index_pin) pos_count = '0;
            n = used_slots(drained);
            if (n == 0) begin
                // empty log still gives one zero beat
                r = '{count: pos_count, dir: 2'b00, slot: 8'h00, ovf: ovf, last: 1'b1};
                expected_reports.push_back(r);
            end
            for (int k = 0; k < n; k++) begin
                r = '{count: pos_count, dir: 2'b00, slot: drained[k][7:0], ovf: ovf,
                      last: (k == n - 1)};
                expected_reports.push_back(r);
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // idle lengths: mostly short, a few long, with calm stretches
    // ---------------------------------------------------------------
    int send_calm = 0;
    int recv_calm = 0;

    function automatic int idle_len(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_left = $urandom_range(20, 50);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 9);
        return $urandom_range(15, 40);
    endfunction

    // ---------------------------------------------------------------
    // driver: offers queued items, predicts on each accepted beat
    // ---------------------------------------------------------------
    enc_item_t cur_item;
    int        send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) decode_item(cur_item);
            // a new beat goes out only once the current one is taken
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (encoder_items.size() > 0) begin
                    cur_item = encoder_items.pop_front();
                    i_valid     <= 1'b1;
                    i_cmd       <= cur_item.cmd;
                    i_pin_a     <= cur_item.pin_a;
                    i_pin_b     <= cur_item.pin_b;
                    i_index_pin <= cur_item.index_pin;
                    send_gap = idle_len(send_calm);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: checks result beats and drives the receiver stall
    // ---------------------------------------------------------------
    int          beats_taken = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          stall_left = 0;
    int          ready_left = 0;
    enc_report_t want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                beats_taken++;
                if (expected_reports.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with none expected, count_value %0d",
                             $time, $signed(o_count_value));
                end else begin
                    want = expected_reports.pop_front();
                    if (o_count_value !== want.count) begin
                        errors++;
                        $display("%0t: count_value expected %0d actual %0d", $time,
                                 $signed(want.count), $signed(o_count_value));
                    end
                    if (o_step_dir !== want.dir) begin
                        errors++;
                        $display("%0t: step_dir expected %0d actual %0d", $time,
                                 $signed(want.dir), $signed(o_step_dir));
                    end
                    if (o_slot_value !== want.slot) begin
                        errors++;
                        $display("%0t: slot_value expected %0d actual %0d", $time,
                                 $signed(want.slot), $signed(o_slot_value));
                    end
                    if (o_log_overflow !== want.ovf) begin
                        errors++;
                        $display("%0t: log_overflow expected %b actual %b", $time,
                                 want.ovf, o_log_overflow);
                    end
                    if (o_last_of_run !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run expected %b actual %b", $time,
                                 want.last, o_last_of_run);
                    end
                end
            end
            // one long hold so the decoder fills up and backs off its input
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && beats_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (ready_left > 0) begin
                ready_left--;
                i_stall <= 1'b0;
            end else begin
                ready_left = $urandom_range(0, 5);
                stall_left = idle_len(recv_calm);
                i_stall <= 1'b0;
            end
        end
    end

    // watchdog
    int cycles = 0;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    logic [1:0] gen_phase = 2'd0;    // phase the stimulus believes the decoder is in

    function automatic void add_item(input logic cmd, input logic a, input logic b,
                                     input logic idx);
        encoder_items.push_back('{cmd: cmd, pin_a: a, pin_b: b, index_pin: idx});
        items_made++;
    endfunction

    // one clean quadrature step; index pin is don't-care on samples
    function automatic void add_move(input bit up);
        logic [1:0] pins;
        pins = up ? FWD_PINS[gen_phase] : BACK_PINS[gen_phase];
        add_item(CMD_SAMPLE, pins[0], pins[1], 1'($urandom_range(0, 1)));
        gen_phase = up ? gen_phase + 2'd1 : gen_phase - 2'd1;
    endfunction

    // pins 00 then a=1 park any phase in S1
    function automatic void add_resync();
        add_item(CMD_SAMPLE, 1'b0, 1'b0, 1'($urandom_range(0, 1)));
        add_item(CMD_SAMPLE, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
        gen_phase = 2'd1;
    endfunction

    function automatic void add_noise();
        int n;
        n = $urandom_range(2, 5);
        repeat (n)
            add_item(($urandom_range(0, 3) == 0) ? CMD_POLL : CMD_SAMPLE,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        add_resync();
    endfunction

    // direction runs of random length, then a poll; many runs overflow the log
    function automatic void add_episode();
        int runs;
        int len;
        bit up;
        add_resync();
        runs = $urandom_range(1, 11);
        up = 1'($urandom_range(0, 1));
        repeat (runs) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 2);
            repeat (len) add_move(up);
            if ($urandom_range(0, 4) != 0) up = !up;
        end
        if ($urandom_range(0, 5) == 0) add_noise();
        add_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 9) < 3));
        // a second poll now sees an empty log
        if ($urandom_range(0, 9) == 0)
            add_item(CMD_POLL, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    endfunction

    function automatic void add_random(input int budget);
        int start;
        start = items_made;
        while (items_made - start < budget) begin
            if ($urandom_range(0, 9) == 0) add_noise();
            else add_episode();
        end
    endfunction

    // ---------------------------------------------------------------
    // apb writes, only while the decoder is idle
    // ---------------------------------------------------------------
    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_MODE: res_mode = value[1:0];
            REG_CMIN: cnt_min  = value;
            REG_CMAX: cnt_max  = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] mode, input logic [31:0] lo,
                             input logic [31:0] hi);
        apb_write(REG_MODE, {30'b0, mode});
        apb_write(REG_CMIN, lo);
        apb_write(REG_CMAX, hi);
    endtask

    // nothing queued, nothing offered, nothing owed, then a short settle
    task automatic wait_idle();
        do @(negedge i_clk);
        while (encoder_items.size() > 0 || i_valid || expected_reports.size() > 0);
        repeat (4) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        reset_decoder();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset config, x4 and full range
        add_item(CMD_POLL, 1'b0, 1'b0, 1'b0);     // empty log right after reset
        add_move(1'b1);                           // first sample counts, not logged
        repeat (3) add_move(1'b1);
        repeat (3) add_move(1'b0);
        add_item(CMD_SAMPLE, 1'b1, 1'b1, 1'b1);   // both pins at once
        add_resync();
        add_item(CMD_POLL, 1'b0, 1'b1, 1'b1);     // drain then index clear
        add_item(CMD_POLL, 1'b1, 1'b1, 1'b0);     // log already empty
        for (int k = 0; k < 10; k++) add_move(k % 2 == 0);   // ten runs, two lost
        add_item(CMD_POLL, 1'b1, 1'b0, 1'b0);
        add_random(1);
        wait_idle();

        // one count selector, moderate window
        configure(RES_X1, -32'sd20, 32'sd20);
        add_random(1);
        wait_idle();

        // two count selector, narrow window that saturates quickly
        configure(RES_X2, -32'sd2, 32'sd3);
        add_random(1);
        wait_idle();

        // spare selector code, limits inverted at the extremes
        configure(MODE_X4_ALIAS, 32'h7FFF_FFFF, 32'h8000_0000);
        add_random(1);
        wait_idle();

        // mildly inverted limits
        configure(MODE_X4, 32'sd5, -32'sd5);
        add_item(CMD_POLL, 1'b0, 1'b0, 1'b1);
        add_random(1);
        wait_idle();

        // zero-width window
        configure(MODE_X4, 32'sd0, 32'sd0);
        add_random(1);
        wait_idle();

        // full range again; long runs fill slots to +127 and -128
        configure(MODE_X4, 32'h8000_0000, 32'h7FFF_FFFF);
        add_resync();
        repeat (128) add_move(1'b1);
        repeat (129) add_move(1'b0);
        add_item(CMD_POLL, 1'b0, 1'b0, 1'b0);
        wait_idle();

        repeat (10) @(negedge i_clk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
